FILE: hw/rtl/nba_pkg.sv
package nba_pkg;

    localparam int COORD_BITS      = 12;
    localparam int ANGLE_W         = 16;
    localparam int INDEX_W         = 4;
    localparam int DIST_W          = 2 * COORD_BITS + 1;
    localparam int ACTIVE_W        = 5;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 5;
    localparam int MAX_ENTRIES_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT  = 1'd1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_COUNT_RST = 5'd16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_ASSOC = 1'b1;

    localparam logic MODE_EUCLID_SQ = 1'b0;
    localparam logic MODE_MANHATTAN = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HEAD,
        ST_TAIL,
        ST_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        SRC_CENTRE,
        SRC_HEAD,
        SRC_TAIL
    } t_src;

    typedef struct packed {
        t_coord             x;
        t_coord             y;
        logic [ANGLE_W-1:0] angle;
    } t_centre_ent;

    typedef struct packed {
        t_coord head_x;
        t_coord head_y;
        t_coord tail_x;
        t_coord tail_y;
    } t_ends_ent;

    typedef struct packed {
        logic wr_entry;
        logic assoc_start;
        logic issue;
        t_src src;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: hw/rtl/nba_in_if.sv
interface nba_in_if import nba_pkg::*;;
    logic               valid;
    logic               ready;
    logic               command;
    logic [INDEX_W-1:0] index;
    t_coord             com_x;
    t_coord             com_y;
    logic [ANGLE_W-1:0] angle;
    t_coord             head_x;
    t_coord             head_y;
    t_coord             tail_x;
    t_coord             tail_y;

    modport source (
        output valid, command, index, com_x, com_y, angle, head_x, head_y, tail_x, tail_y,
        input  ready
    );
    modport sink (
        input  valid, command, index, com_x, com_y, angle, head_x, head_y, tail_x, tail_y,
        output ready
    );
endinterface

FILE: hw/rtl/nba_out_if.sv
interface nba_out_if import nba_pkg::*;;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] track_number;
    logic [INDEX_W-1:0] matched_entry;
    logic [DIST_W-1:0]  best_distance;
    t_coord             out_head_x;
    t_coord             out_head_y;
    t_coord             out_tail_x;
    t_coord             out_tail_y;
    logic               swapped;

    modport source (
        output valid, track_number, matched_entry, best_distance,
               out_head_x, out_head_y, out_tail_x, out_tail_y, swapped,
        input  ready
    );
    modport sink (
        input  valid, track_number, matched_entry, best_distance,
               out_head_x, out_head_y, out_tail_x, out_tail_y, swapped,
        output ready
    );
endinterface

FILE: hw/rtl/nba_ctrl.sv
module nba_ctrl import nba_pkg::*; #(
    parameter  int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int EW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_command,
    output logic          o_in_ready,
    input  logic [EW-1:0] i_last_idx,
    input  t_dp_sts       i_sts,
    output t_dp_cmd       o_cmd,
    output logic [EW-1:0] o_scan_addr
);

    t_state        r_state, n_state;
    logic [EW-1:0] r_j, n_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_command == CMD_ASSOC) begin
                        o_cmd.assoc_start = 1'b1;
                        n_state           = ST_SCAN;
                        n_j               = '0;
                    end else begin
                        o_cmd.wr_entry = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                o_cmd.src   = SRC_CENTRE;
                if (r_j == i_last_idx) begin
                    n_state = ST_HEAD;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_HEAD: begin
                o_cmd.issue = 1'b1;
                o_cmd.src   = SRC_HEAD;
                n_state     = ST_TAIL;
            end
            ST_TAIL: begin
                o_cmd.issue = 1'b1;
                o_cmd.src   = SRC_TAIL;
                n_state     = ST_DRAIN;
            end
            ST_DRAIN: begin
                // wait for the distance pipeline and a free output register
                if (!i_sts.busy && i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_scan_addr = r_j;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_j <= i_last_idx))
        else $error("scan counter past last active entry");

    a_assoc_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.assoc_start |=> (r_state == ST_SCAN && r_j == '0))
        else $error("associate beat did not start a scan at entry zero");

    a_drain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAIL) |=> (r_state == ST_DRAIN && i_sts.busy))
        else $error("pipeline empty straight after tail issue");

endmodule

FILE: hw/rtl/nba_dp.sv
module nba_dp import nba_pkg::*; #(
    parameter  int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int EW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    input  logic [EW-1:0]         i_scan_addr,
    output t_dp_sts               o_sts,
    output logic [EW-1:0]         o_last_idx,
    input  logic [INDEX_W-1:0]    i_index,
    input  t_coord                i_com_x,
    input  t_coord                i_com_y,
    input  logic [ANGLE_W-1:0]    i_angle,
    input  t_coord                i_head_x,
    input  t_coord                i_head_y,
    input  t_coord                i_tail_x,
    input  t_coord                i_tail_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [INDEX_W-1:0]    o_track_number,
    output logic [INDEX_W-1:0]    o_matched_entry,
    output logic [DIST_W-1:0]     o_best_distance,
    output t_coord                o_out_head_x,
    output t_coord                o_out_head_y,
    output t_coord                o_out_tail_x,
    output t_coord                o_out_tail_y,
    output logic                  o_swapped
);

    // configuration
    logic                r_distance_mode;
    logic [ACTIVE_W-1:0] r_active_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_mode <= MODE_EUCLID_SQ;
            r_active_count  <= ACTIVE_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DISTANCE_MODE: r_distance_mode <= i_cfg_data[0];
                REG_ACTIVE_COUNT:  r_active_count  <= i_cfg_data[ACTIVE_W-1:0];
            endcase
        end
    end

    // clamp to 1 .. MAX_ENTRIES, given as last index
    always_comb begin
        if (r_active_count == '0) begin
            o_last_idx = '0;
        end else if (32'(r_active_count) > MAX_ENTRIES) begin
            o_last_idx = EW'(MAX_ENTRIES - 1);
        end else begin
            o_last_idx = EW'(r_active_count - 1'b1);
        end
    end

    // index folded into the table depth
    logic [EW-1:0] w_kmap [2**INDEX_W];
    for (genvar g = 0; g < 2**INDEX_W; g++) begin : g_kmap
        assign w_kmap[g] = EW'(g % MAX_ENTRIES);
    end

    logic [EW-1:0] w_k;
    assign w_k = w_kmap[i_index];

    // track under association
    logic [EW-1:0] r_k;
    t_coord        r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.assoc_start) begin
            r_k  <= w_k;
            r_cx <= i_com_x;
            r_cy <= i_com_y;
        end
    end

    // centre and angle table, read by the scan
    t_centre_ent r_mem_ca [MAX_ENTRIES];
    t_centre_ent r_ca_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry) begin
            r_mem_ca[w_k] <= '{x: i_com_x, y: i_com_y, angle: i_angle};
        end
        r_ca_rd <= r_mem_ca[i_scan_addr];
    end

    // end point table, read at the track entry
    t_ends_ent     r_mem_ends [MAX_ENTRIES];
    t_ends_ent     r_ends_rd;
    t_ends_ent     w_ends_final;
    t_ends_ent     w_ends_wd;
    logic [EW-1:0] w_ends_addr;
    logic          w_ends_we;
    logic          w_swap;

    logic [DIST_W-1:0] r_dh, r_dt;

    assign w_swap       = (r_dh < r_dt);
    assign w_ends_final = w_swap ? '{head_x: r_ends_rd.tail_x, head_y: r_ends_rd.tail_y,
                                     tail_x: r_ends_rd.head_x, tail_y: r_ends_rd.head_y}
                                 : r_ends_rd;
    assign w_ends_we    = i_cmd.wr_entry | i_cmd.finish;
    assign w_ends_addr  = i_cmd.finish ? r_k : w_k;
    assign w_ends_wd    = i_cmd.finish ? w_ends_final
                                       : '{head_x: i_head_x, head_y: i_head_y,
                                           tail_x: i_tail_x, tail_y: i_tail_y};

    always_ff @(posedge i_clk) begin
        if (w_ends_we) begin
            r_mem_ends[w_ends_addr] <= w_ends_wd;
        end
        r_ends_rd <= r_mem_ends[r_k];
    end

    // distance pipeline: read tag, squares, sum, compare
    logic          r_p0_vld, r_p1_vld, r_p2_vld;
    t_src          r_p0_src, r_p1_src, r_p2_src;
    logic [EW-1:0] r_p0_j, r_p1_j, r_p2_j;
    logic [ANGLE_W-1:0] r_p1_ang, r_p2_ang;
    logic [2*COORD_BITS-1:0] r_sqx, r_sqy;
    logic [COORD_BITS:0]     r_sum;
    logic [DIST_W-1:0]       r_d;

    t_coord w_ax, w_ay, w_dx, w_dy;

    always_comb begin
        w_ax = r_ca_rd.x;
        w_ay = r_ca_rd.y;
        unique case (r_p0_src)
            SRC_HEAD: begin
                w_ax = r_ends_rd.head_x;
                w_ay = r_ends_rd.head_y;
            end
            SRC_TAIL: begin
                w_ax = r_ends_rd.tail_x;
                w_ay = r_ends_rd.tail_y;
            end
            default: begin
                w_ax = r_ca_rd.x;
                w_ay = r_ca_rd.y;
            end
        endcase
        w_dx = (w_ax > r_cx) ? w_ax - r_cx : r_cx - w_ax;
        w_dy = (w_ay > r_cy) ? w_ay - r_cy : r_cy - w_ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p0_vld <= i_cmd.issue;
            r_p1_vld <= r_p0_vld;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0_src <= i_cmd.src;
        r_p0_j   <= i_scan_addr;
        r_p1_src <= r_p0_src;
        r_p1_j   <= r_p0_j;
        r_p1_ang <= r_ca_rd.angle;
        r_sqx    <= (2*COORD_BITS)'(w_dx) * (2*COORD_BITS)'(w_dx);
        r_sqy    <= (2*COORD_BITS)'(w_dy) * (2*COORD_BITS)'(w_dy);
        r_sum    <= {1'b0, w_dx} + {1'b0, w_dy};
        r_p2_src <= r_p1_src;
        r_p2_j   <= r_p1_j;
        r_p2_ang <= r_p1_ang;
        r_d      <= (r_distance_mode == MODE_MANHATTAN)
                    ? DIST_W'(r_sum) : DIST_W'(r_sqx) + DIST_W'(r_sqy);
    end

    // running best; first entry always taken, tie goes to larger angle
    logic [DIST_W-1:0]  r_best_d;
    logic [EW-1:0]      r_best_j;
    logic [ANGLE_W-1:0] r_best_ang;

    always_ff @(posedge i_clk) begin
        if (r_p2_vld) begin
            unique case (r_p2_src)
                SRC_HEAD: r_dh <= r_d;
                SRC_TAIL: r_dt <= r_d;
                default: begin
                    if (r_p2_j == '0 || r_d < r_best_d) begin
                        r_best_d   <= r_d;
                        r_best_j   <= r_p2_j;
                        r_best_ang <= r_p2_ang;
                    end else if (r_d == r_best_d && r_p2_ang > r_best_ang) begin
                        r_best_j   <= r_p2_j;
                        r_best_ang <= r_p2_ang;
                    end
                end
            endcase
        end
    end

    // output register
    logic r_out_valid;
    logic w_busy;

    assign w_busy = r_p0_vld | r_p1_vld | r_p2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_track_number  <= INDEX_W'(r_k);
            o_matched_entry <= INDEX_W'(r_best_j);
            o_best_distance <= r_best_d;
            o_out_head_x    <= w_ends_final.head_x;
            o_out_head_y    <= w_ends_final.head_y;
            o_out_tail_x    <= w_ends_final.tail_x;
            o_out_tail_y    <= w_ends_final.tail_y;
            o_swapped       <= w_swap;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.busy     = w_busy;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    a_finish_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !w_busy)
        else $error("result taken while distance pipeline still busy");

    a_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p2_vld && r_p2_src == SRC_TAIL) |=> !w_busy)
        else $error("beat left in pipeline behind tail distance");

    a_finish_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished result not held in output register");

endmodule

FILE: hw/rtl/nearest_blob_association_core.sv
// channel  dir  beat carries
// i_in     in   command, index, centre, angle, head and tail points
// o_out    out  track, matched entry, distance, end points after swap, swap flag
// i_cfg_*  in   distance_mode (index 0), active_count (index 1)
//
// a write beat is taken in the idle state; an associate beat scans the n active entries of
// the centre table one entry a cycle, then sends head and tail through the same
// three-stage distance pipeline.
// reset is synchronous and active low; it clears control and configuration, the
// entry tables hold nothing defined until written.
// the output register keeps a result while o_out stalls; new beats are still taken and
// a following associate waits at its end until the register frees.
module nearest_blob_association_core import nba_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    nba_in_if.sink                i_in,
    nba_out_if.source             o_out
);

    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_dp_cmd       w_cmd;
    t_dp_sts       w_sts;
    logic [EW-1:0] w_last_idx;
    logic [EW-1:0] w_scan_addr;
    logic          w_in_ready;

    nba_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .o_in_ready   (w_in_ready),
        .i_last_idx   (w_last_idx),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_scan_addr  (w_scan_addr)
    );

    assign i_in.ready = w_in_ready;

    nba_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .i_scan_addr     (w_scan_addr),
        .o_sts           (w_sts),
        .o_last_idx      (w_last_idx),
        .i_index         (i_in.index),
        .i_com_x         (i_in.com_x),
        .i_com_y         (i_in.com_y),
        .i_angle         (i_in.angle),
        .i_head_x        (i_in.head_x),
        .i_head_y        (i_in.head_y),
        .i_tail_x        (i_in.tail_x),
        .i_tail_y        (i_in.tail_y),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_track_number  (o_out.track_number),
        .o_matched_entry (o_out.matched_entry),
        .o_best_distance (o_out.best_distance),
        .o_out_head_x    (o_out.out_head_x),
        .o_out_head_y    (o_out.out_head_y),
        .o_out_tail_x    (o_out.out_tail_x),
        .o_out_tail_y    (o_out.out_tail_y),
        .o_swapped       (o_out.swapped)
    );

endmodule
